FILE: rtl/core/tpl_pkg.sv
package tpl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  // Width of every coordinate port and of the bound registers
  localparam int FIELD_BITS = 16;

  // Depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_OOB   = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  // Configuration register indexes (paddr[2])
  localparam logic REG_BOUND_W = 1'b0;
  localparam logic REG_BOUND_H = 1'b1;

  // Request kinds after classification in the front
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_CLEAR,
    CMD_LOCATE,
    CMD_OOB
  } cmd_kind_t;

  // One queued request; a locate carries its point in coord[0] and coord[1]
  typedef struct packed {
    cmd_kind_t                   kind;
    logic [5:0][FIELD_BITS-1:0]  coord;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/core/triangle_point_locator.sv
// Triangle point locator: linear scan over a table of clockwise triangles.
// Requests enter on start and are taken at an edge where start is high and
// busy is low. op selects load (append a triangle from vert_*), clear (empty
// the table) or locate (test query_x/query_y); an unused op is taken and
// dropped. Only a locate returns a result: one cycle of done with tri_index,
// on_perimeter and status. The receiver cannot stall; results are never held.
// A front stage classifies requests and checks the bounds, a two-entry queue
// decouples it from the back end, which owns the triangle memory and runs the
// scan. Loads and clears retire as they leave the queue and do not hold the
// back end. A locate in bounds holds the back end until it reaches the first
// containing triangle, or to the end of the table fill for a miss. The scan
// tests one triangle per cycle through a memory read stage and a product
// stage. An out of bounds or empty-table locate answers in the cycle after it
// leaves the queue. busy is high while the queue is full. Bounds are set
// through the APB port (bound_width at 0x0, bound_height at 0x4); the user
// must write them only while the block is idle, which the block does not
// enforce. Reset empties the table and queue and sets both bounds to 65535;
// the triangle memory is not cleared and needs no clearing pass.
module triangle_point_locator
  import tpl_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op,
  input  logic [FIELD_BITS-1:0] vert_a_x,
  input  logic [FIELD_BITS-1:0] vert_a_y,
  input  logic [FIELD_BITS-1:0] vert_b_x,
  input  logic [FIELD_BITS-1:0] vert_b_y,
  input  logic [FIELD_BITS-1:0] vert_c_x,
  input  logic [FIELD_BITS-1:0] vert_c_y,
  input  logic [FIELD_BITS-1:0] query_x,
  input  logic [FIELD_BITS-1:0] query_y,
  output logic                  done,
  output logic [7:0]            tri_index,
  output logic                  on_perimeter,
  output logic [1:0]            status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  queue_status_t q_stat;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          pop_cmd;

  // Classify requests and hold configuration
  tpl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .vert_a_x (vert_a_x),
    .vert_a_y (vert_a_y),
    .vert_b_x (vert_b_x),
    .vert_b_y (vert_b_y),
    .vert_c_x (vert_c_x),
    .vert_c_y (vert_c_y),
    .query_x  (query_x),
    .query_y  (query_y),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Decouple front and back
  tpl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // Execute requests against the triangle table
  tpl_back #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .done         (done),
    .tri_index    (tri_index),
    .on_perimeter (on_perimeter),
    .status       (status)
  );

endmodule

FILE: rtl/core/tpl_front.sv
module tpl_front
  import tpl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            op,
  input  logic [FIELD_BITS-1:0] vert_a_x,
  input  logic [FIELD_BITS-1:0] vert_a_y,
  input  logic [FIELD_BITS-1:0] vert_b_x,
  input  logic [FIELD_BITS-1:0] vert_b_y,
  input  logic [FIELD_BITS-1:0] vert_c_x,
  input  logic [FIELD_BITS-1:0] vert_c_y,
  input  logic [FIELD_BITS-1:0] query_x,
  input  logic [FIELD_BITS-1:0] query_y,
  input  queue_status_t         q_stat,
  output logic                  busy,
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  logic [FIELD_BITS-1:0] bound_width;
  logic [FIELD_BITS-1:0] bound_height;
  logic                  cfg_wr;
  logic                  accept;
  logic [FIELD_BITS-1:0] qx;
  logic [FIELD_BITS-1:0] qy;
  logic                  oob;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_width  <= '1;
      bound_height <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BOUND_W: bound_width  <= pwdata[FIELD_BITS-1:0];
        REG_BOUND_H: bound_height <= pwdata[FIELD_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BOUND_W: prdata = 32'(bound_width);
      REG_BOUND_H: prdata = 32'(bound_height);
      default:     prdata = '0;
    endcase
  end

  // Accept while the queue has room
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  // Reduce coordinates to the working width
  assign qx  = FIELD_BITS'(query_x[CW-1:0]);
  assign qy  = FIELD_BITS'(query_y[CW-1:0]);
  assign oob = (qx > bound_width) || (qy > bound_height);

  // Classify the request; an unused opcode is dropped
  always_comb begin
    push_cmd.coord[0] = FIELD_BITS'(vert_a_x[CW-1:0]);
    push_cmd.coord[1] = FIELD_BITS'(vert_a_y[CW-1:0]);
    push_cmd.coord[2] = FIELD_BITS'(vert_b_x[CW-1:0]);
    push_cmd.coord[3] = FIELD_BITS'(vert_b_y[CW-1:0]);
    push_cmd.coord[4] = FIELD_BITS'(vert_c_x[CW-1:0]);
    push_cmd.coord[5] = FIELD_BITS'(vert_c_y[CW-1:0]);
    push_cmd.kind     = CMD_LOAD;
    push              = 1'b0;
    unique case (op)
      OP_LOAD: begin
        push_cmd.kind = CMD_LOAD;
        push          = accept;
      end
      OP_CLEAR: begin
        push_cmd.kind = CMD_CLEAR;
        push          = accept;
      end
      OP_LOCATE: begin
        push_cmd.coord[0] = qx;
        push_cmd.coord[1] = qy;
        push_cmd.kind     = oob ? CMD_OOB : CMD_LOCATE;
        push              = accept;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/tpl_queue.sv
module tpl_queue
  import tpl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          pop_cmd,
  output queue_status_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_stat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign pop_cmd      = slots[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/tpl_back.sv
module tpl_back
  import tpl_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_stat,
  input  cmd_t          pop_cmd,
  output logic          pop,
  output logic          done,
  output logic [7:0]    tri_index,
  output logic          on_perimeter,
  output logic [1:0]    status
);

  localparam int CW    = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int ENT_W = 6 * CW;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int IDX_W = $clog2(MAX_TRIANGLES);
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  issue_cnt;
  logic [CW-1:0]     q_x;
  logic [CW-1:0]     q_y;

  logic [ENT_W-1:0]  mem [MAX_TRIANGLES];
  logic [ENT_W-1:0]  rd_data;
  logic [ENT_W-1:0]  wr_data;
  logic              mem_wr;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_last;
  logic              s2_valid;
  logic [IDX_W-1:0]  s2_idx;
  logic              s2_last;
  logic signed [PW-1:0] lp_next [3];
  logic signed [PW-1:0] rp_next [3];
  logic signed [PW-1:0] lp [3];
  logic signed [PW-1:0] rp [3];
  logic              outside;
  logic              on_edge;
  logic [IDX_W+7:0]  idx_ext;

  // Take the next request whenever no scan is running
  assign pop    = (state == S_IDLE) && !q_stat.empty;
  assign mem_wr = pop && (pop_cmd.kind == CMD_LOAD) && (cnt < CNT_W'(MAX_TRIANGLES));
  assign wr_data = {pop_cmd.coord[5][CW-1:0], pop_cmd.coord[4][CW-1:0],
                    pop_cmd.coord[3][CW-1:0], pop_cmd.coord[2][CW-1:0],
                    pop_cmd.coord[1][CW-1:0], pop_cmd.coord[0][CW-1:0]};

  // Triangle store: append at the fill count, read at the scan pointer
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[cnt[IDX_W-1:0]] <= wr_data;
    end
    rd_data <= mem[issue_cnt[IDX_W-1:0]];
  end

  // Edge products for the triangle just read, one lane per edge
  for (genvar k = 0; k < 3; k++) begin : g_edge
    localparam int N = (k == 2) ? 0 : k + 1;
    logic [CW-1:0]        ux, uy, vx, vy;
    logic signed [DW-1:0] dvx, dvy, dpx, dpy;

    assign ux  = rd_data[2*k*CW +: CW];
    assign uy  = rd_data[(2*k+1)*CW +: CW];
    assign vx  = rd_data[2*N*CW +: CW];
    assign vy  = rd_data[(2*N+1)*CW +: CW];
    assign dvx = $signed({1'b0, vx}) - $signed({1'b0, ux});
    assign dvy = $signed({1'b0, vy}) - $signed({1'b0, uy});
    assign dpx = $signed({1'b0, q_x}) - $signed({1'b0, ux});
    assign dpy = $signed({1'b0, q_y}) - $signed({1'b0, uy});
    assign lp_next[k] = dvx * dpy;
    assign rp_next[k] = dvy * dpx;
  end

  // Register the products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lp[k] <= lp_next[k];
      rp[k] <= rp_next[k];
    end
  end

  // Outside on any counter-clockwise edge, on the perimeter on any zero edge
  always_comb begin
    outside = 1'b0;
    on_edge = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (lp[k] > rp[k]) outside = 1'b1;
      if (lp[k] == rp[k]) on_edge = 1'b1;
    end
  end

  assign idx_ext = {8'b0, s2_idx};

  // Sequencer: execute requests and run the scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      issue_cnt <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done     <= 1'b0;
      s2_valid <= s1_valid;
      s2_idx   <= s1_idx;
      s2_last  <= s1_last;
      unique case (state)
        S_IDLE: begin
          s1_valid <= 1'b0;
          s2_valid <= 1'b0;
          if (pop) begin
            unique case (pop_cmd.kind)
              CMD_LOAD: begin
                if (mem_wr) cnt <= cnt + CNT_W'(1);
              end
              CMD_CLEAR: begin
                cnt <= '0;
              end
              CMD_OOB: begin
                done         <= 1'b1;
                tri_index    <= '0;
                on_perimeter <= 1'b0;
                status       <= ST_OOB;
              end
              CMD_LOCATE: begin
                if (cnt == '0) begin
                  done         <= 1'b1;
                  tri_index    <= '0;
                  on_perimeter <= 1'b0;
                  status       <= ST_NONE;
                end else begin
                  q_x       <= pop_cmd.coord[0][CW-1:0];
                  q_y       <= pop_cmd.coord[1][CW-1:0];
                  issue_cnt <= '0;
                  state     <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (s2_valid && !outside) begin
            // First containing triangle: report and drop the rest
            done         <= 1'b1;
            tri_index    <= idx_ext[7:0];
            on_perimeter <= on_edge;
            status       <= ST_FOUND;
            s1_valid     <= 1'b0;
            s2_valid     <= 1'b0;
            state        <= S_IDLE;
          end else if (s2_valid && s2_last) begin
            done         <= 1'b1;
            tri_index    <= '0;
            on_perimeter <= 1'b0;
            status       <= ST_NONE;
            s1_valid     <= 1'b0;
            s2_valid     <= 1'b0;
            state        <= S_IDLE;
          end else if (issue_cnt < cnt) begin
            s1_valid  <= 1'b1;
            s1_idx    <= issue_cnt[IDX_W-1:0];
            s1_last   <= (issue_cnt == cnt - CNT_W'(1));
            issue_cnt <= issue_cnt + CNT_W'(1);
          end else begin
            s1_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_TRIANGLES))
    else $error("triangle count above capacity");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> state == S_SCAN)
    else $error("scan pipeline active outside a scan");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_cnt <= cnt)
    else $error("scan pointer past the table");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_FOUND || status == ST_OOB || status == ST_NONE))
    else $error("undefined status code");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_FOUND |-> tri_index == '0 && !on_perimeter)
    else $error("miss result carries index or perimeter flag");

endmodule

FILE: test/tb_triangle_point_locator.sv
module tb_triangle_point_locator;
  import tpl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_DEPTH    = MAX_TRIANGLES_DEF;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = MAX_TRIANGLES_DEF + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 255;
  localparam int FILL_PHASE     = 4;

  typedef logic [FIELD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0] op;
    coord_t     ax, ay, bx, by, cx, cy;
    coord_t     qx, qy;
  } request_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy;
  } triangle_t;

  typedef struct packed {
    logic [7:0] tri_index;
    logic       on_perimeter;
    logic [1:0] status;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    answer_t  ans;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [1:0]   op = OP_LOAD;
  coord_t       vert_a_x = '0;
  coord_t       vert_a_y = '0;
  coord_t       vert_b_x = '0;
  coord_t       vert_b_y = '0;
  coord_t       vert_c_x = '0;
  coord_t       vert_c_y = '0;
  coord_t       query_x = '0;
  coord_t       query_y = '0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic         busy;
  logic         done;
  logic [7:0]   tri_index;
  logic         on_perimeter;
  logic [1:0]   status;
  logic [31:0]  prdata;
  logic         pready;

  // Mirror of the block: triangle table, fill level and bounds
  triangle_t    tri_table [TABLE_DEPTH];
  int unsigned  tri_fill = 0;
  coord_t       bound_w = 16'hFFFF;
  coord_t       bound_h = 16'hFFFF;

  answer_t      pending_answers [$];
  dir_row_t     dir_rows [$];

  int errors = 0;
  int n_req = 0;
  int n_dropped_loads = 0;
  int n_answers = 0;
  int n_found = 0;
  int n_perim = 0;
  int n_oob = 0;
  int n_miss = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  triangle_point_locator u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .vert_a_x     (vert_a_x),
    .vert_a_y     (vert_a_y),
    .vert_b_x     (vert_b_x),
    .vert_b_y     (vert_b_y),
    .vert_c_x     (vert_c_x),
    .vert_c_y     (vert_c_y),
    .query_x      (query_x),
    .query_y      (query_y),
    .done         (done),
    .tri_index    (tri_index),
    .on_perimeter (on_perimeter),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Sign of (v-u)x(p-u): positive is counter-clockwise
  function automatic int edge_side(input longint ux, input longint uy, input longint vx,
                                   input longint vy, input longint px, input longint py);
    longint l;
    longint r;
    l = (vx - ux) * (py - uy);
    r = (vy - uy) * (px - ux);
    if (l > r) return 1;
    if (l < r) return -1;
    return 0;
  endfunction

  // 1 outside, 0 on an edge or vertex, -1 strictly inside
  function automatic int classify_point(input triangle_t t, input coord_t px, input coord_t py);
    int s0;
    int s1;
    int s2;
    s0 = edge_side(t.ax, t.ay, t.bx, t.by, px, py);
    s1 = edge_side(t.bx, t.by, t.cx, t.cy, px, py);
    s2 = edge_side(t.cx, t.cy, t.ax, t.ay, px, py);
    if (s0 > 0 || s1 > 0 || s2 > 0) return 1;
    if (s0 == 0 || s1 == 0 || s2 == 0) return 0;
    return -1;
  endfunction

  // Scan the table in load order for the first triangle holding the point
  function automatic answer_t locate_point(input coord_t px, input coord_t py);
    answer_t a;
    int c;
    a = '0;
    if (px > bound_w || py > bound_h) begin
      a.status = ST_OOB;
      return a;
    end
    for (int i = 0; i < tri_fill; i++) begin
      c = classify_point(tri_table[i], px, py);
      if (c <= 0) begin
        a.tri_index = 8'(i);
        a.on_perimeter = (c == 0);
        a.status = ST_FOUND;
        return a;
      end
    end
    a.status = ST_NONE;
    return a;
  endfunction

  // Advance the mirror by one request; return 1 when it yields a result
  function automatic logic apply_request(input request_t r, output answer_t a);
    a = '0;
    case (r.op)
      OP_LOAD: begin
        if (tri_fill < TABLE_DEPTH) begin
          tri_table[tri_fill] = {r.ax, r.ay, r.bx, r.by, r.cx, r.cy};
          tri_fill++;
        end else begin
          n_dropped_loads++;
        end
      end
      OP_CLEAR: tri_fill = 0;
      OP_LOCATE: begin
        a = locate_point(r.qx, r.qy);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic request_t blank_request(input logic [1:0] o);
    request_t r;
    r = {o, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  // Random triangle: wide, tiny near a corner, or local; mostly clockwise
  function automatic triangle_t random_triangle();
    int kind;
    int ox;
    int oy;
    int span;
    int base;
    int px [3];
    int py [3];
    int tmp;
    longint orient;
    kind = $urandom_range(0, 9);
    ox = $urandom_range(0, 65535);
    oy = $urandom_range(0, 65535);
    span = $urandom_range(1, 2000);
    base = $urandom_range(0, 1) ? 65520 : 0;
    for (int k = 0; k < 3; k++) begin
      if (kind < 4) begin
        px[k] = $urandom_range(0, 65535);
        py[k] = $urandom_range(0, 65535);
      end else if (kind < 7) begin
        px[k] = base + $urandom_range(0, 15);
        py[k] = base + $urandom_range(0, 15);
      end else begin
        px[k] = int'(clamp_coord(ox + int'($urandom_range(0, 2 * span)) - span));
        py[k] = int'(clamp_coord(oy + int'($urandom_range(0, 2 * span)) - span));
      end
    end
    orient = longint'(px[1] - px[0]) * (py[2] - py[0])
           - longint'(py[1] - py[0]) * (px[2] - px[0]);
    // flip most counter-clockwise draws so the table is mostly well formed
    if (orient > 0 && $urandom_range(0, 9) != 0) begin
      tmp = px[1]; px[1] = px[2]; px[2] = tmp;
      tmp = py[1]; py[1] = py[2]; py[2] = tmp;
    end
    return {16'(px[0]), 16'(py[0]), 16'(px[1]), 16'(py[1]), 16'(px[2]), 16'(py[2])};
  endfunction

  function automatic request_t load_request();
    request_t r;
    r = blank_request(OP_LOAD);
    {r.ax, r.ay, r.bx, r.by, r.cx, r.cy} = random_triangle();
    return r;
  endfunction

  // Aim the query at random points, vertices, centroids, edges and the bound lines
  function automatic request_t locate_request();
    request_t r;
    triangle_t t;
    int k;
    int sel;
    int vx [3];
    int vy [3];
    r = blank_request(OP_LOCATE);
    k = $urandom_range(0, 9);
    if (tri_fill == 0 || k < 2) return r;
    t = tri_table[$urandom_range(0, tri_fill - 1)];
    vx = '{int'(t.ax), int'(t.bx), int'(t.cx)};
    vy = '{int'(t.ay), int'(t.by), int'(t.cy)};
    case (k)
      2, 3: begin
        sel = $urandom_range(0, 2);
        r.qx = 16'(vx[sel]);
        r.qy = 16'(vy[sel]);
      end
      4, 5, 6: begin
        r.qx = 16'((vx[0] + vx[1] + vx[2]) / 3);
        r.qy = 16'((vy[0] + vy[1] + vy[2]) / 3);
      end
      7: begin
        r.qx = 16'((vx[0] + vx[1]) / 2);
        r.qy = 16'((vy[0] + vy[1]) / 2);
      end
      8: begin
        r.qx = clamp_coord((vx[0] + vx[1] + vx[2]) / 3 + int'($urandom_range(0, 4)) - 2);
        r.qy = clamp_coord((vy[0] + vy[1] + vy[2]) / 3 + int'($urandom_range(0, 4)) - 2);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          r.qx = clamp_coord(int'(bound_w) + int'($urandom_range(0, 1)));
          r.qy = 16'($urandom_range(0, bound_h));
        end else begin
          r.qx = 16'($urandom_range(0, bound_w));
          r.qy = clamp_coord(int'(bound_h) + int'($urandom_range(0, 1)));
        end
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t load_row(input int ax, input int ay, input int bx,
                                        input int by, input int cx, input int cy);
    dir_row_t d;
    d = '0;
    d.req.op = OP_LOAD;
    {d.req.ax, d.req.ay, d.req.bx, d.req.by, d.req.cx, d.req.cy} =
      {16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy)};
    return d;
  endfunction

  function automatic dir_row_t locate_row(input int qx, input int qy);
    dir_row_t d;
    d = '0;
    d.req.op = OP_LOCATE;
    d.req.qx = 16'(qx);
    d.req.qy = 16'(qy);
    return d;
  endfunction

  function automatic dir_row_t answer_row(input int qx, input int qy, input int idx,
                                          input logic perim, input logic [1:0] st);
    dir_row_t d;
    d = locate_row(qx, qy);
    d.typed = 1'b1;
    d.ans = '{tri_index: 8'(idx), on_perimeter: perim, status: st};
    return d;
  endfunction

  function automatic dir_row_t op_row(input logic [1:0] o);
    dir_row_t d;
    d = '0;
    d.req = {o, {8{16'hFFFF}}};
    return d;
  endfunction

  // Present one request, wait for it to be taken, then record its result
  task automatic issue(input request_t r, input logic typed, input answer_t typed_ans);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    vert_a_x <= r.ax;
    vert_a_y <= r.ay;
    vert_b_x <= r.bx;
    vert_b_y <= r.by;
    vert_c_x <= r.cx;
    vert_c_y <= r.cy;
    query_x <= r.qx;
    query_y <= r.qy;
    @(negedge clk);
    while (busy) @(negedge clk);
    if (r.op != OP_UNUSED) n_req++;
    if (apply_request(r, a)) begin
      pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
    end
    @(posedge clk);
  endtask

  // Drop start and let the block drain before touching the registers
  task automatic settle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one bound register, then read it back
  task automatic reg_write(input logic idx, input coord_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_BOUND_W) bound_w = value;
    else bound_h = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata[15:0] !== value) begin
      $error("prdata at %0d: expected %0d, got %0d", {idx, 2'b00}, value, prdata[15:0]);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One sequence: optional unused request, optional clear, a run of loads, then locates with stray loads
  task automatic run_episode(input logic fill);
    int n_loads;
    int n_locates;
    if ($urandom_range(0, 99) < 5) issue(blank_request(OP_UNUSED), 1'b0, '0);
    if (fill || $urandom_range(0, 9) < 7) issue(blank_request(OP_CLEAR), 1'b0, '0);
    n_loads = fill ? TABLE_DEPTH + 3 : $urandom_range(1, 12);
    repeat (n_loads) issue(load_request(), 1'b0, '0);
    n_locates = fill ? 8 : $urandom_range(1, 10);
    repeat (n_locates) begin
      if ($urandom_range(0, 9) == 0) issue(load_request(), 1'b0, '0);
      else issue(locate_request(), 1'b0, '0);
    end
  endtask

  // Check each result against the oldest expected answer
  always @(negedge clk) begin : result_check
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no locate request pending: tri_index %0d status %0d",
               tri_index, status);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        n_answers++;
        if (want.status == ST_FOUND) n_found++;
        if (want.status == ST_OOB) n_oob++;
        if (want.status == ST_NONE) n_miss++;
        if (want.on_perimeter) n_perim++;
        if (tri_index !== want.tri_index) begin
          $error("tri_index: expected %0d, got %0d", want.tri_index, tri_index);
          errors++;
        end
        if (on_perimeter !== want.on_perimeter) begin
          $error("on_perimeter: expected %0d, got %0d", want.on_perimeter, on_perimeter);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(negedge clk) begin
    if ((start && !busy) || done || (psel && penable)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("** triangle_point_locator: FAILED **");
      $finish;
    end
  end

  initial begin
    int base_count;
    int idle_plan [NUM_PHASES];
    coord_t w;
    coord_t h;
    idle_plan = '{0, 88, 29, 88, 0, 29};

    // Directed requests at reset bounds
    dir_rows = {
      answer_row(0, 0, 0, 1'b0, ST_NONE),
      op_row(OP_UNUSED),
      load_row(0, 0, 0, 65535, 65535, 0),
      answer_row(0, 0, 0, 1'b1, ST_FOUND),
      answer_row(1, 1, 0, 1'b0, ST_FOUND),
      answer_row(65535, 65535, 0, 1'b0, ST_NONE),
      load_row(65535, 65535, 65535, 0, 0, 65535),
      answer_row(65535, 65535, 1, 1'b1, ST_FOUND),
      answer_row(32768, 32767, 0, 1'b1, ST_FOUND),
      locate_row(65535, 1),
      op_row(OP_CLEAR),
      answer_row(1, 1, 0, 1'b0, ST_NONE),
      load_row(0, 0, 100, 100, 200, 200),
      load_row(0, 0, 65535, 0, 0, 65535),
      answer_row(50, 50, 0, 1'b1, ST_FOUND),
      locate_row(10, 20),
      locate_row(65535, 0),
      locate_row(300, 300),
      load_row(65535, 65535, 65535, 65535, 65535, 65535),
      locate_row(65535, 65535),
      op_row(OP_UNUSED),
      locate_row(0, 65535)
    };

    // Hold reset, then release
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ans);

    // Random phases, each with its own bounds and idle rate
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin w = 16'hFFFF; h = 16'hFFFF; end
        1: begin w = 16'd1; h = 16'd1; end
        2: begin w = 16'd1; h = 16'hFFFF; end
        3: begin w = 16'hFFFF; h = 16'd1; end
        default: begin
          w = 16'($urandom_range(32768, 65535));
          h = 16'($urandom_range(32768, 65535));
        end
      endcase
      reg_write(REG_BOUND_W, w);
      reg_write(REG_BOUND_H, h);
      idle_pct = idle_plan[ph];
      base_count = n_req - n_dropped_loads;
      run_episode(ph == FILL_PHASE);
      while (n_req - n_dropped_loads < base_count + PHASE_ITEMS) run_episode(1'b0);
    end

    // Drain, then let the back end go quiet
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests; checked %0d results: %0d found (%0d on a perimeter),",
             n_req, n_answers, n_found, n_perim);
    $display("%0d out of bounds, %0d unmatched; %0d loads dropped on a full table.",
             n_oob, n_miss, n_dropped_loads);
    if (errors == 0) begin
      $display("** triangle_point_locator: PASSED **");
    end else begin
      $display("** triangle_point_locator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: triangle_point_locator.f
rtl/core/tpl_pkg.sv
rtl/core/tpl_front.sv
rtl/core/tpl_queue.sv
rtl/core/tpl_back.sv
rtl/core/triangle_point_locator.sv
test/tb_triangle_point_locator.sv
